### rtl/core/nlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nlt_pkg
// Shared types and constants for the neighbor liveness table.
// ---------------------------------------------------------------------------
package nlt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH  = 16;
    localparam int NODE_ID_BITS = 64;
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Port field widths
    localparam int OP_W   = 2;
    localparam int ID_W   = 64;
    localparam int KIND_W = 3;
    localparam int AGE_W  = 8;

    localparam logic [AGE_W-1:0] AGE_MAX       = '1;
    localparam logic [AGE_W-1:0] LIFETIME_INIT = AGE_W'(5);

    typedef logic [NODE_ID_BITS-1:0] t_node;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [AGE_W-1:0]        t_age;

    // Input operation codes
    typedef enum logic [OP_W-1:0] {
        OP_HELLO  = 2'd0,
        OP_TICK   = 2'd1,
        OP_PAUSE  = 2'd2,
        OP_RESUME = 2'd3
    } t_op;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD          = 3'd0,
        KIND_REMOVE       = 3'd1,
        KIND_RECONNECTED  = 3'd2,
        KIND_DISCONNECTED = 3'd3,
        KIND_ADVERTISE    = 3'd4,
        KIND_FULL         = 3'd5
    } t_kind;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HSCAN,
        ST_HDONE,
        ST_ADD,
        ST_TSCAN,
        ST_FLUSH
    } t_state;

endpackage : nlt_pkg
`default_nettype wire

### rtl/core/nlt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// nlt_if
// Valid/ready channels of the neighbor liveness table: input items, result
// items and the lifetime configuration write.
// ---------------------------------------------------------------------------
interface nlt_in_if;
    logic                          valid;
    logic                          ready;
    logic [nlt_pkg::OP_W-1:0]      operation;
    logic [nlt_pkg::ID_W-1:0]      neighbor_id;

    modport source (output valid, operation, neighbor_id, input ready);
    modport sink   (input valid, operation, neighbor_id, output ready);
endinterface : nlt_in_if

interface nlt_out_if;
    logic                          valid;
    logic                          ready;
    logic [nlt_pkg::KIND_W-1:0]    kind;
    logic [nlt_pkg::ID_W-1:0]      link_node_id;
    logic                          last;

    modport source (output valid, kind, link_node_id, last, input ready);
    modport sink   (input valid, kind, link_node_id, last, output ready);
endinterface : nlt_out_if

interface nlt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [nlt_pkg::AGE_W-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface : nlt_cfg_if
`default_nettype wire

### rtl/core/neighbor_liveness_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// neighbor_liveness_table
// Neighbor id table with per-entry tick ages; reports link adds, removals,
// reconnect/disconnect, advertisements and full-table rejects.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                          | transfer when
//  i_in     | in  | operation, neighbor_id           | valid & ready
//  o_out    | out | kind, link_node_id, last         | valid & ready
//  i_cfg    | in  | lifetime_ticks (data)            | valid & ready (always ready)
//
//  A hello scans all TABLE_DEPTH entries one per cycle, then decides in
//  ST_HDONE: a known id only has its age cleared, an insert or a full table
//  ends in ST_FLUSH, and reconnected comes first through ST_ADD. A connected
//  tick sweeps the entries one per cycle unless a removal stalls; a
//  disconnected report goes out through ST_FLUSH; pause, resume and silent
//  ticks are handled in idle. The single entry compare/age unit sets the rate. Input ready is high only while idle.
//  A removal stalls the sweep while the output register is still held.
//  Reset (synchronous) clears valid bits, flags and lifetime to 5.
// ---------------------------------------------------------------------------
module neighbor_liveness_table (
    input  wire       i_clk,
    input  wire       i_rst_n,
    nlt_in_if.sink    i_in,
    nlt_out_if.source o_out,
    nlt_cfg_if.sink   i_cfg
);

    // Table storage
    logic [nlt_pkg::TABLE_DEPTH-1:0] r_valid, n_valid;
    nlt_pkg::t_node                  r_node [nlt_pkg::TABLE_DEPTH];
    nlt_pkg::t_age                   r_age  [nlt_pkg::TABLE_DEPTH];

    // Control state
    nlt_pkg::t_state r_state, n_state;
    nlt_pkg::t_idx   r_idx, n_idx;
    nlt_pkg::t_age   r_lifetime;
    logic            r_disc, n_disc;
    logic            r_paused, n_paused;

    // Hello scan results
    nlt_pkg::t_node  r_id, n_id;
    logic            r_hit_v, n_hit_v;
    nlt_pkg::t_idx   r_hit_idx, n_hit_idx;
    logic            r_free_v, n_free_v;
    nlt_pkg::t_idx   r_free_idx, n_free_idx;

    // Pending result (held until its successor, or the end, is known)
    logic            r_pend_v, n_pend_v;
    nlt_pkg::t_kind  r_pend_kind, n_pend_kind;
    nlt_pkg::t_node  r_pend_id, n_pend_id;

    // Output register
    logic            r_out_v, n_out_v;
    nlt_pkg::t_kind  r_out_kind, n_out_kind;
    nlt_pkg::t_node  r_out_id, n_out_id;
    logic            r_out_last, n_out_last;

    // Entry write controls
    logic            age_we;
    nlt_pkg::t_idx   age_widx;
    nlt_pkg::t_age   age_wdata;
    logic            node_we;

    // Shared entry unit: one entry read per cycle
    logic            out_free;
    logic            last_idx;
    nlt_pkg::t_age   age_inc;
    logic            expire;
    logic            id_match;
    logic [nlt_pkg::TABLE_DEPTH-1:0] idx_mask;

    assign out_free = !r_out_v || o_out.ready;
    assign last_idx = (r_idx == nlt_pkg::IDX_W'(nlt_pkg::TABLE_DEPTH - 1));
    assign age_inc  = (r_age[r_idx] == nlt_pkg::AGE_MAX) ? nlt_pkg::AGE_MAX
                                                         : r_age[r_idx] + 1'b1;
    assign expire   = (age_inc > r_lifetime);
    assign id_match = (r_node[r_idx] == r_id);
    assign idx_mask = nlt_pkg::TABLE_DEPTH'(1) << r_idx;

    assign i_in.ready         = (r_state == nlt_pkg::ST_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_out_v;
    assign o_out.kind         = r_out_kind;
    assign o_out.link_node_id = nlt_pkg::ID_W'(r_out_id);
    assign o_out.last         = r_out_last;

    // Next state and outputs
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_disc      = r_disc;
        n_paused    = r_paused;
        n_id        = r_id;
        n_hit_v     = r_hit_v;
        n_hit_idx   = r_hit_idx;
        n_free_v    = r_free_v;
        n_free_idx  = r_free_idx;
        n_pend_v    = r_pend_v;
        n_pend_kind = r_pend_kind;
        n_pend_id   = r_pend_id;
        n_out_v     = r_out_v && !o_out.ready;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_last  = r_out_last;
        age_we      = 1'b0;
        age_widx    = r_idx;
        age_wdata   = age_inc;
        node_we     = 1'b0;

        unique case (r_state)
            nlt_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_idx = '0;
                    unique case (nlt_pkg::t_op'(i_in.operation))
                        nlt_pkg::OP_HELLO: begin
                            n_id     = nlt_pkg::NODE_ID_BITS'(i_in.neighbor_id);
                            n_hit_v  = 1'b0;
                            n_free_v = 1'b0;
                            n_state  = nlt_pkg::ST_HSCAN;
                        end
                        nlt_pkg::OP_TICK: begin
                            n_pend_id = '0;
                            if (!r_disc) begin
                                n_pend_v    = 1'b1;
                                n_pend_kind = nlt_pkg::KIND_ADVERTISE;
                                n_state     = nlt_pkg::ST_TSCAN;
                            end else if (!r_paused) begin
                                n_pend_v    = 1'b1;
                                n_pend_kind = nlt_pkg::KIND_DISCONNECTED;
                                n_state     = nlt_pkg::ST_FLUSH;
                            end
                        end
                        nlt_pkg::OP_PAUSE:  n_paused = 1'b1;
                        nlt_pkg::OP_RESUME: n_paused = 1'b0;
                        default: ;
                    endcase
                end
            end

            // Hello lookup: match and first free slot, one entry a cycle
            nlt_pkg::ST_HSCAN: begin
                if (r_valid[r_idx]) begin
                    if (!r_hit_v && id_match) begin
                        n_hit_v   = 1'b1;
                        n_hit_idx = r_idx;
                    end
                end else if (!r_free_v) begin
                    n_free_v   = 1'b1;
                    n_free_idx = r_idx;
                end
                n_idx = r_idx + 1'b1;
                if (last_idx) begin
                    n_state = nlt_pkg::ST_HDONE;
                end
            end

            nlt_pkg::ST_HDONE: begin
                n_pend_id = r_id;
                if (r_hit_v) begin
                    age_we    = 1'b1;
                    age_widx  = r_hit_idx;
                    age_wdata = '0;
                    n_state   = nlt_pkg::ST_IDLE;
                end else if (!r_free_v) begin
                    n_pend_v    = 1'b1;
                    n_pend_kind = nlt_pkg::KIND_FULL;
                    n_state     = nlt_pkg::ST_FLUSH;
                end else begin
                    age_we    = 1'b1;
                    age_widx  = r_free_idx;
                    age_wdata = '0;
                    node_we   = 1'b1;
                    n_valid   = r_valid | (nlt_pkg::TABLE_DEPTH'(1) << r_free_idx);
                    n_disc    = 1'b0;
                    n_pend_v  = 1'b1;
                    if (r_valid == '0) begin
                        n_pend_kind = nlt_pkg::KIND_RECONNECTED;
                        n_pend_id   = '0;
                        n_state     = nlt_pkg::ST_ADD;
                    end else begin
                        n_pend_kind = nlt_pkg::KIND_ADD;
                        n_state     = nlt_pkg::ST_FLUSH;
                    end
                end
            end

            // Push reconnected, then hold the new link as the final result
            nlt_pkg::ST_ADD: begin
                if (out_free) begin
                    n_out_v     = 1'b1;
                    n_out_kind  = r_pend_kind;
                    n_out_id    = r_pend_id;
                    n_out_last  = 1'b0;
                    n_pend_kind = nlt_pkg::KIND_ADD;
                    n_pend_id   = r_id;
                    n_state     = nlt_pkg::ST_FLUSH;
                end
            end

            // Tick sweep: age each valid entry, remove expired ones
            nlt_pkg::ST_TSCAN: begin
                if (r_valid[r_idx] && expire) begin
                    if (out_free) begin
                        n_out_v     = 1'b1;
                        n_out_kind  = r_pend_kind;
                        n_out_id    = r_pend_id;
                        n_out_last  = 1'b0;
                        n_pend_kind = nlt_pkg::KIND_REMOVE;
                        n_pend_id   = r_node[r_idx];
                        n_valid     = r_valid & ~idx_mask;
                        if ((r_valid & ~idx_mask) == '0) begin
                            n_disc = 1'b1;
                        end
                        n_idx = r_idx + 1'b1;
                        if (last_idx) begin
                            n_state = nlt_pkg::ST_FLUSH;
                        end
                    end
                end else begin
                    age_we = r_valid[r_idx];
                    n_idx  = r_idx + 1'b1;
                    if (last_idx) begin
                        n_state = nlt_pkg::ST_FLUSH;
                    end
                end
            end

            // Final result of the item
            nlt_pkg::ST_FLUSH: begin
                if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_kind = r_pend_kind;
                    n_out_id   = r_pend_id;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = nlt_pkg::ST_IDLE;
                end
            end

            default: n_state = nlt_pkg::ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= nlt_pkg::ST_IDLE;
            r_valid    <= '0;
            r_disc     <= 1'b0;
            r_paused   <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_lifetime <= nlt_pkg::LIFETIME_INIT;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_disc   <= n_disc;
            r_paused <= n_paused;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
            if (i_cfg.valid) begin
                r_lifetime <= i_cfg.data;
            end
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_id        <= n_id;
        r_hit_v     <= n_hit_v;
        r_hit_idx   <= n_hit_idx;
        r_free_v    <= n_free_v;
        r_free_idx  <= n_free_idx;
        r_pend_kind <= n_pend_kind;
        r_pend_id   <= n_pend_id;
        r_out_kind  <= n_out_kind;
        r_out_id    <= n_out_id;
        r_out_last  <= n_out_last;
    end

    // Entry arrays
    always_ff @(posedge i_clk) begin
        if (age_we) begin
            r_age[age_widx] <= age_wdata;
        end
        if (node_we) begin
            r_node[r_free_idx] <= r_id;
        end
    end

endmodule : neighbor_liveness_table
`default_nettype wire

### dv/neighbor_liveness_table_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// neighbor_liveness_table_test
// Self-checking bench for the neighbor liveness table. A driver feeds
// hellos, ticks, pause and resume from a backlog. A shadow table predicts
// every link report, and a monitor compares each report field by field in
// order. Directed cases come first: empty table, extreme ids and a full
// table. Random traffic over several lifetime settings and a long output
// hold-off follow.
// ---------------------------------------------------------------------------
module neighbor_liveness_table_test;

    localparam int          MAX_REPORTS  = nlt_pkg::TABLE_DEPTH + 1;
    localparam int          DRAIN_CYCLES = 2 * nlt_pkg::TABLE_DEPTH + 8;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          POOL_SIZE    = 20;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    typedef struct {
        nlt_pkg::t_op   op;
        nlt_pkg::t_node id;
    } nbr_op_t;

    typedef struct {
        nlt_pkg::t_kind kind;
        nlt_pkg::t_node node;
        logic           last;
    } link_report_t;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // Bench-driven signals, known from time zero
    logic                     in_valid  = 1'b0;
    logic [nlt_pkg::OP_W-1:0] in_op     = nlt_pkg::OP_TICK;
    logic [nlt_pkg::ID_W-1:0] in_id     = '0;
    logic                     out_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    nlt_pkg::t_age            cfg_data  = '0;

    nlt_in_if  in_ch ();
    nlt_out_if out_ch ();
    nlt_cfg_if cfg_ch ();

    assign in_ch.valid       = in_valid;
    assign in_ch.operation   = in_op;
    assign in_ch.neighbor_id = in_id;
    assign out_ch.ready      = out_ready;
    assign cfg_ch.valid      = cfg_valid;
    assign cfg_ch.data       = cfg_data;

    neighbor_liveness_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Bench bookkeeping
    nbr_op_t      op_backlog [$];
    link_report_t report_queue [$];
    int           ops_queued      = 0;
    int           ops_accepted    = 0;
    int           reports_checked = 0;
    int           cfg_writes      = 0;
    int           err_cnt         = 0;
    bit           in_taken        = 1'b0;
    bit           out_taken       = 1'b0;
    int           hold_req_cnt    = 0;
    int           hold_ack_cnt    = 0;
    int           hold_left       = 0;
    int unsigned  cycle_cnt       = 0;

    // Shadow table state
    logic           tbl_valid [nlt_pkg::TABLE_DEPTH];
    nlt_pkg::t_node tbl_node  [nlt_pkg::TABLE_DEPTH];
    nlt_pkg::t_age  tbl_age   [nlt_pkg::TABLE_DEPTH];
    logic           link_down;
    logic           paused;
    nlt_pkg::t_age  life_limit;

    function automatic bit table_is_empty();
        int i;
        for (i = 0; i < nlt_pkg::TABLE_DEPTH; i++) begin
            if (tbl_valid[i]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic link_report_t mk_report(input nlt_pkg::t_kind kind,
                                               input nlt_pkg::t_node node);
        link_report_t r;
        r.kind = kind;
        r.node = node;
        r.last = 1'b0;
        return r;
    endfunction

    // Apply one accepted operation to the shadow table, queue its reports
    task automatic predict_op(input nlt_pkg::t_op op, input nlt_pkg::t_node id);
        link_report_t batch [MAX_REPORTS];
        int           n;
        int           hit;
        int           slot;
        int           i;
        n    = 0;
        hit  = -1;
        slot = -1;
        case (op)
            nlt_pkg::OP_HELLO: begin
                for (i = 0; i < nlt_pkg::TABLE_DEPTH; i++) begin
                    if (tbl_valid[i]) begin
                        if (hit < 0 && tbl_node[i] == id) hit = i;
                    end else if (slot < 0) begin
                        slot = i;
                    end
                end
                if (hit >= 0) begin
                    tbl_age[hit] = '0;
                end else if (slot < 0) begin
                    batch[n++] = mk_report(nlt_pkg::KIND_FULL, id);
                end else begin
                    if (table_is_empty()) begin
                        batch[n++] = mk_report(nlt_pkg::KIND_RECONNECTED, '0);
                    end
                    tbl_valid[slot] = 1'b1;
                    tbl_node[slot]  = id;
                    tbl_age[slot]   = '0;
                    link_down       = 1'b0;
                    batch[n++] = mk_report(nlt_pkg::KIND_ADD, id);
                end
            end
            nlt_pkg::OP_TICK: begin
                if (!link_down) begin
                    batch[n++] = mk_report(nlt_pkg::KIND_ADVERTISE, '0);
                    // age sweep, removals in ascending slot order
                    for (i = 0; i < nlt_pkg::TABLE_DEPTH; i++) begin
                        if (tbl_valid[i]) begin
                            if (tbl_age[i] != nlt_pkg::AGE_MAX) begin
                                tbl_age[i] = tbl_age[i] + 1'b1;
                            end
                            if (tbl_age[i] > life_limit) begin
                                tbl_valid[i] = 1'b0;
                                batch[n++] = mk_report(nlt_pkg::KIND_REMOVE, tbl_node[i]);
                                if (table_is_empty()) link_down = 1'b1;
                            end
                        end
                    end
                end else if (!paused) begin
                    batch[n++] = mk_report(nlt_pkg::KIND_DISCONNECTED, '0);
                end
            end
            nlt_pkg::OP_PAUSE: paused = 1'b1;
            default:           paused = 1'b0;
        endcase
        for (i = 0; i < n; i++) begin
            batch[i].last = (i == n - 1);
            report_queue.push_back(batch[i]);
        end
    endtask

    // Port monitor: transfers, prediction and report checking
    always @(posedge i_clk) begin : watch_ports
        link_report_t want;
        int           i;
        in_taken  = i_rst_n && in_ch.valid && in_ch.ready;
        out_taken = i_rst_n && out_ch.valid && out_ch.ready;
        if (!i_rst_n) begin
            for (i = 0; i < nlt_pkg::TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
            link_down  = 1'b0;
            paused     = 1'b0;
            life_limit = nlt_pkg::LIFETIME_INIT;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) life_limit = cfg_ch.data;
            if (in_taken) begin
                predict_op(nlt_pkg::t_op'(in_ch.operation), in_ch.neighbor_id);
                ops_accepted++;
            end
            if (out_taken) begin
                if (report_queue.size() == 0) begin
                    $error("unexpected report: kind %0d, link_node_id %h",
                           out_ch.kind, out_ch.link_node_id);
                    err_cnt++;
                end else begin
                    want = report_queue.pop_front();
                    if (out_ch.kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
                        err_cnt++;
                    end
                    if (out_ch.link_node_id !== want.node) begin
                        $error("link_node_id: expected %h, actual %h",
                               want.node, out_ch.link_node_id);
                        err_cnt++;
                    end
                    if (out_ch.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, out_ch.last);
                        err_cnt++;
                    end
                    reports_checked++;
                end
            end
        end
    end

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Input driver: one item per transfer, random gap after each
    int send_wait = 0;
    bit send_calm = 1'b0;

    always @(negedge i_clk) begin : drive_ops
        logic    drive_v;
        nbr_op_t cur;
        drive_v = in_valid && !in_taken;
        if (!drive_v) begin
            if (send_wait > 0) begin
                send_wait--;
            end else if (op_backlog.size() > 0) begin
                cur     = op_backlog.pop_front();
                in_op  <= cur.op;
                in_id  <= cur.id;
                drive_v = 1'b1;
                if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
                send_wait = pick_gap(send_calm);
            end
        end
        in_valid <= drive_v;
    end

    // Report receiver: random stall after each transfer, plus hold-off
    int recv_wait = 0;
    bit recv_calm = 1'b0;

    always @(negedge i_clk) begin : accept_reports
        if (out_taken) begin
            if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
            recv_wait = pick_gap(recv_calm);
        end else if (recv_wait > 0) begin
            recv_wait--;
        end
        out_ready <= (recv_wait == 0) && (hold_left == 0);
    end

    // Long receiver hold-off, counted here on request
    always @(posedge i_clk) begin : hold_off
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            hold_left    = HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[neighbor_liveness_table] ERROR");
            $finish;
        end
    end

    task automatic queue_op(input nlt_pkg::t_op op, input nlt_pkg::t_node id);
        nbr_op_t item;
        item.op = op;
        item.id = id;
        op_backlog.push_back(item);
        ops_queued++;
    endtask

    // Wait until every item is in and every report out, then let the block settle
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (ops_accepted != ops_queued || report_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_lifetime(input nlt_pkg::t_age value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk);
        while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic nlt_pkg::t_node rand_id();
        return {$urandom, $urandom};
    endfunction

    // Stimulus sequence
    initial begin : run_phases
        nlt_pkg::t_node id_pool [POOL_SIZE];
        nlt_pkg::t_node fill_ids [nlt_pkg::TABLE_DEPTH];
        nlt_pkg::t_age  phase_life [4];
        int             phase_len [4];
        int             k;
        int             p;
        int             pick;
        int             base;
        nlt_pkg::t_node nid;

        for (k = 0; k < POOL_SIZE; k++) id_pool[k] = rand_id();
        phase_life[0] = '0;
        phase_life[1] = nlt_pkg::AGE_W'(3);
        phase_life[2] = nlt_pkg::AGE_W'($urandom_range(1, 254));
        phase_life[3] = nlt_pkg::AGE_MAX;
        phase_len[0]  = 30;
        phase_len[1]  = 40;
        phase_len[2]  = 30;
        phase_len[3]  = 30;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(negedge i_clk);

        // Directed: empty table, extreme ids, disconnect, pause
        write_lifetime(nlt_pkg::AGE_W'(1));
        @(posedge i_clk);
        queue_op(nlt_pkg::OP_TICK, rand_id());     // empty connected tick: advertise only
        queue_op(nlt_pkg::OP_HELLO, '0);           // reconnected, then add
        queue_op(nlt_pkg::OP_HELLO, '1);
        queue_op(nlt_pkg::OP_HELLO, '0);           // known: silent
        queue_op(nlt_pkg::OP_TICK, rand_id());
        queue_op(nlt_pkg::OP_HELLO, '0);           // refresh age
        queue_op(nlt_pkg::OP_TICK, rand_id());     // all-ones id ages out
        queue_op(nlt_pkg::OP_TICK, rand_id());     // last entry out, disconnected
        queue_op(nlt_pkg::OP_TICK, rand_id());     // disconnected report
        queue_op(nlt_pkg::OP_PAUSE, '1);
        queue_op(nlt_pkg::OP_TICK, rand_id());     // paused: silent
        queue_op(nlt_pkg::OP_HELLO, 64'h5555_5555_5555_5555); // insert while paused and down
        queue_op(nlt_pkg::OP_RESUME, '1);
        queue_op(nlt_pkg::OP_HELLO, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_op(nlt_pkg::OP_HELLO, 64'h8000_0000_0000_0001);
        queue_op(nlt_pkg::OP_TICK, '0);
        queue_op(nlt_pkg::OP_TICK, '0);            // three removals, ascending
        queue_op(nlt_pkg::OP_PAUSE, rand_id());
        queue_op(nlt_pkg::OP_RESUME, rand_id());
        queue_op(nlt_pkg::OP_TICK, rand_id());
        wait_quiet();

        // Full table at the top lifetime
        write_lifetime(nlt_pkg::AGE_MAX);
        @(posedge i_clk);
        for (k = 0; k < nlt_pkg::TABLE_DEPTH; k++) begin
            fill_ids[k] = rand_id();
            queue_op(nlt_pkg::OP_HELLO, fill_ids[k]);
        end
        queue_op(nlt_pkg::OP_HELLO, rand_id());    // table full
        queue_op(nlt_pkg::OP_HELLO, fill_ids[0]);
        wait_quiet();

        // Random traffic, mostly hellos from a small id pool and ticks
        for (p = 0; p < 4; p++) begin
            write_lifetime(phase_life[p]);
            @(posedge i_clk);
            base = ops_queued;
            for (k = 0; k < phase_len[p]; k++) begin
                pick = $urandom_range(0, 99);
                nid  = ($urandom_range(0, 99) < 85) ?
                       id_pool[$urandom_range(0, POOL_SIZE - 1)] : rand_id();
                if (pick < 50)      queue_op(nlt_pkg::OP_HELLO, nid);
                else if (pick < 88) queue_op(nlt_pkg::OP_TICK, nid);
                else if (pick < 94) queue_op(nlt_pkg::OP_PAUSE, nid);
                else                queue_op(nlt_pkg::OP_RESUME, nid);
            end
            if (p == 1) begin
                wait (ops_accepted >= base + 10);
                @(negedge i_clk);
                hold_req_cnt++;
            end
            wait_quiet();
        end

        $display("Covered %0d operations and %0d link reports over %0d lifetime writes,",
                 ops_accepted, reports_checked, cfg_writes);
        $display("with a full table and a %0d-cycle output hold-off.", HOLD_CYCLES);
        if (err_cnt == 0) begin
            $display("[neighbor_liveness_table] OK");
        end else begin
            $display("[neighbor_liveness_table] ERROR");
        end
        $finish;
    end

endmodule : neighbor_liveness_table_test

### filelist.f
rtl/core/nlt_pkg.sv
rtl/core/nlt_if.sv
rtl/core/neighbor_liveness_table.sv
dv/neighbor_liveness_table_test.sv
